// File: design/assert_macros.svh
// assertion macros for the histogram core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// check a property including during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: design/tbh_pkg.sv
// package with shared types and constants of the histogram core
`default_nettype none
package tbh_pkg;
    localparam int NUM_BINS = 64;
    localparam int PTR_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(NUM_BINS + 1);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_WINDOW = 2'd1;
    localparam logic [1:0] CMD_TOTAL = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_FAR = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHECK, S_WIN_DIV, S_DIVIDE, S_ALIGN, S_CLEAR,
        S_ACCUM_RD, S_ACCUM, S_ADD_RD, S_ADD_WR, S_READ_RD, S_READ, S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_sel_win;
        logic lim_load;
        logic apply_align;
        logic clear_wr;
        logic init_wr;
        logic sum_clr;
        logic rd_sum;
        logic sum_acc;
        logic rd_add;
        logic add_wr;
        logic rd_read;
        logic set_zero;
        logic set_err_far;
        logic set_err_idx;
        logic set_value;
        logic out_load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic win_too_far;
        logic idx_bad;
        logic clear_done;
        logic sum_done;
        logic init_done;
        logic out_free;
        logic [1:0] cmd;
    } stat_t;
endpackage
`default_nettype wire

// File: design/tbh_ram.sv
// generic single port ram with registered read
`default_nettype none
module tbh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule
`default_nettype wire

// File: design/tbh_div.sv
// radix-2 restoring divider, 32-bit dividend over 16-bit divisor
`default_nettype none
module tbh_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [15:0]      remainder
);
    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;
    logic [17:0] diff;

    // one quotient bit per cycle
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg[15:0], q_reg[31]};
        diff = {1'b0, trial} - {2'b0, divisor};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            n_next = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[17]) begin
                r_next = diff[16:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // result registers hold once the last bit is in
    assign done = !busy_reg;
    assign quotient = q_reg;
    assign remainder = r_reg[15:0];
endmodule
`default_nettype wire

// File: design/tbh_datapath.sv
// datapath: item registers, bin ram, divider, pointers and sums
`default_nettype none
module tbh_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tbh_pkg::ctrl_t ctrl,
    output tbh_pkg::stat_t      stat,
    input  wire logic [129:0]   s_data,
    input  wire logic [15:0]    cfg_width,
    output logic [71:0]         m_data,
    output logic                m_valid,
    input  wire logic           m_ready
);
    localparam int PW = tbh_pkg::PTR_W;
    localparam int CW = tbh_pkg::CNT_W;

    logic [1:0]  cmd_reg;
    logic [31:0] now_reg;
    logic [63:0] bytes_reg;
    logic [23:0] win_reg;
    logic [7:0]  off_reg;
    logic [PW-1:0] yp_reg, yp_next;
    logic [31:0] last_reg, last_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] val_reg, val_next;
    logic [1:0]  st_reg, st_next;
    logic [71:0] out_reg;
    logic        ov_reg, ov_next;
    logic [15:0] w;
    logic [31:0] age, dvd;
    logic [32:0] age_r;
    logic        div_start;
    logic        div_done;
    logic [31:0] quo;
    logic [15:0] rem;
    logic [39:0] depth;
    logic        we;
    logic [PW-1:0] addr;
    logic [63:0] wdata, rdata;
    logic [CW-1:0] moves;

    assign w = (cfg_width == 16'd0) ? 16'd1 : cfg_width;
    assign age = now_reg - last_reg;
    assign age_r = {1'b0, age} + {18'b0, w[15:1]};
    assign depth = 40'(tbh_pkg::NUM_BINS) * {24'b0, w};
    // the divider input: window length or rounded age, saturated past 32 bits
    assign dvd = ctrl.div_sel_win ? {8'b0, win_reg} : (age_r[32] ? '1 : age_r[31:0]);
    assign div_start = ctrl.div_start;

    tbh_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(dvd),
        .divisor(w), .done(div_done), .quotient(quo), .remainder(rem)
    );

    // moves capped at the bin count, none for negative age
    always_comb begin
        if (now_reg < last_reg) begin
            moves = '0;
        end else if (quo > 32'(tbh_pkg::NUM_BINS)) begin
            moves = CW'(tbh_pkg::NUM_BINS);
        end else begin
            moves = quo[CW-1:0];
        end
    end

    // ram address and write selection
    always_comb begin
        we = 1'b0;
        wdata = '0;
        addr = yp_reg + idx_reg[PW-1:0];
        if (ctrl.init_wr || ctrl.clear_wr) begin
            we = 1'b1;
        end else if (ctrl.add_wr) begin
            we = 1'b1;
            wdata = rdata + bytes_reg;
            addr = yp_reg;
        end else if (ctrl.rd_add) begin
            addr = yp_reg;
        end else if (ctrl.rd_read) begin
            addr = yp_reg + off_reg[PW-1:0];
        end
    end

    tbh_ram #(.WIDTH(64), .DEPTH(tbh_pkg::NUM_BINS)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // state update
    always_comb begin
        yp_next = yp_reg;
        last_next = last_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        lim_next = lim_reg;
        sum_next = sum_reg;
        val_next = val_reg;
        st_next = st_reg;
        ov_next = ov_reg;
        if (ctrl.init_wr || ctrl.clear_wr) begin
            idx_next = idx_reg + CW'(1);
        end
        if (ctrl.div_start && ctrl.div_sel_win) begin
            idx_next = '0;
        end
        if (ctrl.div_start && !ctrl.div_sel_win) begin
            idx_next = '0;
        end
        if (ctrl.apply_align) begin
            yp_next = yp_reg - moves[PW-1:0];
            cnt_next = moves;
            last_next = now_reg;
            idx_next = '0;
        end
        if (ctrl.load_item) begin
            lim_next = CW'(tbh_pkg::NUM_BINS);
        end
        // window length in bins, rounded up
        if (ctrl.lim_load) begin
            lim_next = (rem != 16'd0) ? CW'(quo + 32'd1) : CW'(quo);
        end
        if (ctrl.sum_clr) begin
            sum_next = '0;
            idx_next = '0;
        end
        if (ctrl.rd_sum) begin
            idx_next = idx_reg + CW'(1);
        end
        if (ctrl.sum_acc) begin
            sum_next = sum_reg + rdata;
        end
        if (ctrl.set_zero) begin
            val_next = '0;
            st_next = tbh_pkg::ST_OK;
        end
        if (ctrl.set_err_far) begin
            val_next = '0;
            st_next = tbh_pkg::ST_TOO_FAR;
        end
        if (ctrl.set_err_idx) begin
            val_next = '0;
            st_next = tbh_pkg::ST_BAD_INDEX;
        end
        if (ctrl.set_value) begin
            val_next = (cmd_reg == tbh_pkg::CMD_READ) ? rdata : sum_reg;
            st_next = tbh_pkg::ST_OK;
        end
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        if (ctrl.out_load) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yp_reg <= '0;
            last_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            yp_reg <= yp_next;
            last_reg <= last_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
        lim_reg <= lim_next;
        sum_reg <= sum_next;
        val_reg <= val_next;
        st_reg <= st_next;
        if (ctrl.load_item) begin
            cmd_reg <= s_data[1:0];
            now_reg <= s_data[33:2];
            bytes_reg <= s_data[97:34];
            win_reg <= s_data[121:98];
            off_reg <= s_data[129:122];
        end
        if (ctrl.out_load) begin
            out_reg <= {6'b0, st_reg, val_reg};
        end
    end

    assign stat.div_done = div_done;
    assign stat.win_too_far = {16'b0, win_reg} > depth;
    assign stat.idx_bad = off_reg > 8'(tbh_pkg::NUM_BINS - 1);
    assign stat.clear_done = idx_reg >= cnt_reg;
    assign stat.sum_done = idx_reg >= lim_reg;
    assign stat.init_done = idx_reg == CW'(tbh_pkg::NUM_BINS - 1);
    assign stat.out_free = !ov_reg;
    assign stat.cmd = cmd_reg;
    assign m_data = out_reg;
    assign m_valid = ov_reg;
endmodule
`default_nettype wire

// File: design/tbh_ctrl.sv
// controller state machine sequencing each command
`default_nettype none
module tbh_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tbh_pkg::stat_t stat,
    output tbh_pkg::ctrl_t      ctrl,
    output tbh_pkg::state_t     state
);
    tbh_pkg::state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tbh_pkg::S_INIT: if (stat.init_done) state_next = tbh_pkg::S_IDLE;
            tbh_pkg::S_IDLE: if (s_valid) state_next = tbh_pkg::S_CHECK;
            tbh_pkg::S_CHECK: begin
                case (stat.cmd)
                    tbh_pkg::CMD_WINDOW: state_next = stat.win_too_far ?
                        tbh_pkg::S_OUT : tbh_pkg::S_WIN_DIV;
                    tbh_pkg::CMD_READ: state_next = stat.idx_bad ?
                        tbh_pkg::S_OUT : tbh_pkg::S_READ_RD;
                    default: state_next = tbh_pkg::S_DIVIDE;
                endcase
            end
            tbh_pkg::S_WIN_DIV: if (stat.div_done) state_next = tbh_pkg::S_DIVIDE;
            tbh_pkg::S_DIVIDE: if (stat.div_done) state_next = tbh_pkg::S_ALIGN;
            tbh_pkg::S_ALIGN: state_next = tbh_pkg::S_CLEAR;
            tbh_pkg::S_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = (stat.cmd == tbh_pkg::CMD_ADD) ?
                        tbh_pkg::S_ADD_RD : tbh_pkg::S_ACCUM_RD;
                end
            end
            tbh_pkg::S_ACCUM_RD: state_next = stat.sum_done ? tbh_pkg::S_OUT : tbh_pkg::S_ACCUM;
            tbh_pkg::S_ACCUM: state_next = tbh_pkg::S_ACCUM_RD;
            tbh_pkg::S_ADD_RD: state_next = tbh_pkg::S_ADD_WR;
            tbh_pkg::S_ADD_WR: state_next = tbh_pkg::S_OUT;
            tbh_pkg::S_READ_RD: state_next = tbh_pkg::S_READ;
            tbh_pkg::S_READ: state_next = tbh_pkg::S_OUT;
            tbh_pkg::S_OUT: if (stat.out_free) state_next = tbh_pkg::S_IDLE;
            default: state_next = tbh_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl = '0;
        s_ready = 1'b0;
        case (state_reg)
            tbh_pkg::S_INIT: ctrl.init_wr = 1'b1;
            tbh_pkg::S_IDLE: begin
                s_ready = 1'b1;
                ctrl.load_item = s_valid;
            end
            tbh_pkg::S_CHECK: begin
                ctrl.sum_clr = 1'b1;
                ctrl.set_zero = 1'b1;
                if (stat.cmd == tbh_pkg::CMD_WINDOW) begin
                    ctrl.set_err_far = stat.win_too_far;
                    // window length to bins first, then the age
                    ctrl.div_start = !stat.win_too_far;
                    ctrl.div_sel_win = 1'b1;
                end else if (stat.cmd == tbh_pkg::CMD_READ) begin
                    ctrl.set_err_idx = stat.idx_bad;
                end else begin
                    ctrl.div_start = 1'b1;
                end
            end
            // take the window bin count and start the age divide
            tbh_pkg::S_WIN_DIV: begin
                ctrl.lim_load = stat.div_done;
                ctrl.div_start = stat.div_done;
            end
            tbh_pkg::S_DIVIDE: begin
                ctrl.div_sel_win = 1'b0;
            end
            tbh_pkg::S_ALIGN: ctrl.apply_align = 1'b1;
            // clear aged bins, then restart the bin index for the sum
            tbh_pkg::S_CLEAR: begin
                ctrl.clear_wr = !stat.clear_done;
                ctrl.sum_clr = stat.clear_done;
            end
            tbh_pkg::S_ACCUM_RD: begin
                ctrl.rd_sum = !stat.sum_done;
                ctrl.set_value = stat.sum_done;
            end
            tbh_pkg::S_ACCUM: ctrl.sum_acc = 1'b1;
            tbh_pkg::S_ADD_RD: ctrl.rd_add = 1'b1;
            tbh_pkg::S_ADD_WR: ctrl.add_wr = 1'b1;
            tbh_pkg::S_READ_RD: ctrl.rd_read = 1'b1;
            tbh_pkg::S_READ: ctrl.set_value = 1'b1;
            tbh_pkg::S_OUT: ctrl.out_load = stat.out_free;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbh_pkg::S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;
endmodule
`default_nettype wire

// File: design/time_binned_byte_rate_histogram_core.sv
// Top level of the time-binned byte histogram core.
// The time from input to result valid depends on the command and on the number of cleared
// bins, and for a window sum also on the number of window bins; the serial divider and the
// ram port set it.
// One item at a time: the next is taken in the cycle after the result is loaded, later if full.
// Reset: synchronous active low; a clearing pass zeroes the bin ram, no transaction.
`default_nettype none
`include "assert_macros.svh"
module time_binned_byte_rate_histogram_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command[1:0], now_secs[33:2], byte_count[97:34], window_secs[121:98],
    // bin_offset[129:122], zero fill
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // value[63:0], status[65:64], zero fill
    output logic [71:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);
    tbh_pkg::ctrl_t  ctrl;
    tbh_pkg::stat_t  stat;
    tbh_pkg::state_t state;
    logic [15:0] width_reg;

    // bin width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 16'd60;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    tbh_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_tvalid), .s_ready(s_tready),
        .stat(stat), .ctrl(ctrl), .state(state)
    );

    tbh_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .s_data(s_tdata[129:0]), .cfg_width(width_reg),
        .m_data(m_tdata), .m_valid(m_tvalid), .m_ready(m_tready)
    );

    `ASSERT_CLK(a_no_accept_busy, aclk, aresetn,
        s_tvalid && s_tready |=> !s_tready, "accepted while busy")
    `ASSERT_CLK(a_status_range, aclk, aresetn,
        m_tvalid |-> m_tdata[65:64] != 2'd3, "illegal status")
    `ASSERT_CLK(a_ready_idle, aclk, aresetn,
        s_tready == (state == tbh_pkg::S_IDLE), "ready outside idle")
    `ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> !m_tvalid, "output valid after reset")
endmodule
`default_nettype wire

// File: tb/sv/time_binned_byte_rate_histogram_core_tb.sv
// testbench for the time-binned byte histogram core: directed and random items against a predictor
`default_nettype none
module time_binned_byte_rate_histogram_core_tb;
    import tbh_pkg::*;

    typedef struct packed {
        logic [65:64] status;
        logic [63:0]  value;
    } hist_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // command[1:0], now_secs[33:2], byte_count[97:34], window_secs[121:98],
    // bin_offset[129:122], zero fill
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // value[63:0], status[65:64], zero fill
    logic [71:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    time_binned_byte_rate_histogram_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [63:0]  bin_mirror [NUM_BINS];
    logic [5:0]   youngest_mirror;
    logic [31:0]  last_secs_mirror;
    logic [15:0]  width_mirror;

    hist_result_t expected_q [$];
    int           errors = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           status_count [3] = '{0, 0, 0};
    bit           quiet = 1'b0;      // no idling on either side
    bit           hold_long = 1'b0;  // receiver long hold-off request
    logic [31:0]  gen_now = 32'd0;   // timestamp source for stimulus

    function automatic logic [31:0] eff_width();
        return (width_mirror == 16'd0) ? 32'd1 : {16'd0, width_mirror};
    endfunction

    // move the ring forward to the given time and clear bins that aged out
    function automatic void align_ring(logic [31:0] now);
        logic [63:0] age;
        logic [63:0] q;
        int moves;
        moves = 0;
        if (now >= last_secs_mirror) begin
            age = {32'd0, now} - {32'd0, last_secs_mirror};
            q = (age + {32'd0, eff_width() / 2}) / {32'd0, eff_width()};
            moves = (q > NUM_BINS) ? NUM_BINS : int'(q);
        end
        youngest_mirror = 6'((int'(youngest_mirror) + NUM_BINS - moves) % NUM_BINS);
        for (int i = 0; i < moves; i++)
            bin_mirror[6'(int'(youngest_mirror) + i)] = '0;
        last_secs_mirror = now;
    endfunction

    function automatic logic [63:0] sum_youngest(int count);
        logic [63:0] total;
        total = '0;
        for (int i = 0; i < count; i++)
            total += bin_mirror[6'(int'(youngest_mirror) + i)];
        return total;
    endfunction

    function automatic hist_result_t histogram_outcome(logic [1:0] cmd, logic [31:0] now,
                                                       logic [63:0] bytes, logic [23:0] win,
                                                       logic [7:0] off);
        hist_result_t r;
        logic [31:0] w;
        int count;
        r = '0;
        w = eff_width();
        case (cmd)
            CMD_ADD: begin
                align_ring(now);
                bin_mirror[youngest_mirror] += bytes;
            end
            CMD_WINDOW: begin
                if ({8'd0, win} > NUM_BINS * w) begin
                    r.status = ST_TOO_FAR;
                end else begin
                    count = int'({8'd0, win} / w) + ((({8'd0, win} % w) != 0) ? 1 : 0);
                    align_ring(now);
                    r.value = sum_youngest(count);
                end
            end
            CMD_TOTAL: begin
                align_ring(now);
                r.value = sum_youngest(NUM_BINS);
            end
            default: begin
                if (off > NUM_BINS - 1) r.status = ST_BAD_INDEX;
                else r.value = bin_mirror[6'(int'(youngest_mirror) + int'(off))];
            end
        endcase
        return r;
    endfunction

    function automatic int sender_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // send one item and record its expected result on acceptance
    task automatic send_item(logic [1:0] cmd, logic [31:0] now, logic [63:0] bytes,
                             logic [23:0] win, logic [7:0] off);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, off, win, bytes, now, cmd};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(histogram_outcome(cmd, now, bytes, win, off));
        items_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for the pipeline to drain, then let the block settle
    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (260) @(posedge aclk);
    endtask

    task automatic write_width(logic [15:0] w);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_mirror = w;
    endtask

    // random item with timestamps that mostly advance by a few bins
    task automatic send_random_item();
        logic [1:0] cmd;
        logic [31:0] w;
        logic [23:0] win;
        logic [7:0] off;
        int r;
        w = eff_width();
        r = $urandom_range(0, 99);
        if (r < 80) gen_now += $urandom_range(0, 2 * w);
        else if (r < 90) gen_now += $urandom_range(0, 80 * w);
        else if (r < 96) gen_now -= $urandom_range(1, 3 * w);
        else gen_now = $urandom;
        r = $urandom_range(0, 99);
        cmd = (r < 45) ? CMD_ADD : (r < 70) ? CMD_WINDOW : (r < 82) ? CMD_TOTAL : CMD_READ;
        r = $urandom_range(0, 9);
        if (r < 7) win = 24'($urandom_range(0, NUM_BINS * w));
        else if (r < 9) win = 24'($urandom_range(NUM_BINS * w, 24'hFFFFFF));
        else win = 24'($urandom);
        off = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, NUM_BINS - 1)) : 8'($urandom);
        send_item(cmd, gen_now, {$urandom, $urandom}, win, off);
    endtask

    // receiver readiness
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_long = 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                stall = $urandom_range(0, 99);
                if (stall < 70) m_tready <= 1'b1;
                else if (stall < 97) m_tready <= 1'b0;
                else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge aclk);
                end
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        hist_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[65:64] < 3) status_count[m_tdata[65:64]]++;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: value %h status %0d",
                       m_tdata[63:0], m_tdata[65:64]);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_tdata[63:0] !== exp_r.value) begin
                    $error("value: expected %h, actual %h", exp_r.value, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[65:64] !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_tdata[65:64]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction at all
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 20000) begin
                $display("watchdog expired with %0d results outstanding", expected_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // extremes, every command and the named corner cases
    task automatic test_directed();
        quiet = 1'b1;
        send_item(CMD_ADD, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_item(CMD_ADD, 32'd29, 64'd5, '0, '0);
        send_item(CMD_ADD, 32'd60, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_item(CMD_TOTAL, 32'd90, '0, '0, '0);
        send_item(CMD_WINDOW, 32'd100, '0, 24'd0, '0);
        send_item(CMD_WINDOW, 32'd100, '0, 24'd61, '0);
        send_item(CMD_WINDOW, 32'd100, '0, 24'(NUM_BINS * 60), '0);
        send_item(CMD_WINDOW, 32'd100, '0, 24'(NUM_BINS * 60 + 1), '0);
        send_item(CMD_WINDOW, 32'd100, '0, 24'hFFFFFF, '0);
        send_item(CMD_READ, 32'hFFFF_FFFF, '0, '0, 8'd0);
        send_item(CMD_READ, 32'd0, '0, '0, 8'd1);
        send_item(CMD_READ, 32'd0, '0, '0, 8'd63);
        send_item(CMD_READ, 32'd0, '0, '0, 8'd64);
        send_item(CMD_READ, 32'd0, '0, '0, 8'd255);
        // negative age still records the new time
        send_item(CMD_ADD, 32'd40, 64'd7, '0, '0);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 64'd9, '0, '0);
        send_item(CMD_TOTAL, 32'hFFFF_FFFF, '0, '0, '0);
        send_item(CMD_ADD, 32'd0, 64'd1, '0, '0);
        stop_sending();
        // zero width acts as one second
        write_width(16'd0);
        send_item(CMD_ADD, 32'd3, 64'd11, '0, '0);
        send_item(CMD_WINDOW, 32'd5, '0, 24'd3, '0);
        send_item(CMD_WINDOW, 32'd5, '0, 24'd65, '0);
        send_item(CMD_READ, 32'd5, '0, '0, 8'd2);
        stop_sending();
        quiet = 1'b0;
        gen_now = last_secs_mirror;
    endtask

    // random items across bin widths, extremes among them
    task automatic test_random();
        logic [15:0] widths [6];
        widths = '{16'd1, 16'd7, 16'd60, 16'hFFFF, 16'd3600, 16'($urandom_range(1, 65535))};
        foreach (widths[k]) begin
            write_width(widths[k]);
            gen_now = last_secs_mirror;
            for (int n = 0; n < 190; n++) begin
                quiet = (n >= 60 && n < 90);
                send_random_item();
            end
            quiet = 1'b0;
            stop_sending();
        end
    endtask

    // receiver holds off while the sender keeps offering, then sender waits for all
    task automatic test_backpressure();
        write_width(16'd60);
        gen_now = last_secs_mirror;
        hold_long = 1'b1;
        for (int n = 0; n < 20; n++) send_random_item();
        stop_sending();
        while (expected_q.size() != 0) @(posedge aclk);
        for (int n = 0; n < 20; n++) send_random_item();
        stop_sending();
    endtask

    initial begin
        for (int i = 0; i < NUM_BINS; i++) bin_mirror[i] = '0;
        youngest_mirror = '0;
        last_secs_mirror = '0;
        width_mirror = 16'd60;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        drain();
        $display("covered %0d items over 7 bin widths, %0d results checked", items_sent,
                 results_seen);
        $display("status ok %0d, too far %0d, bad index %0d", status_count[0],
                 status_count[1], status_count[2]);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
